// File: sv/rplm_pkg.sv
package rplm_pkg;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam int CFG_W = 11;

    typedef struct packed {
        logic        op;
        logic [9:0]  entry_index;
        logic [31:0] entry_prefix;
        logic [31:0] entry_mask;
        logic [31:0] entry_next_hop;
        logic [3:0]  entry_port;
        logic [31:0] lookup_address;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [31:0] hop_address;
        logic [3:0]  out_port;
        logic [9:0]  matched_index;
    } rsp_t;

    typedef struct packed {
        logic [31:0] prefix;
        logic [31:0] mask;
        logic [31:0] hop;
        logic [3:0]  port;
    } entry_t;

endpackage

// File: sv/rplm_queue.sv
module rplm_queue #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  T     din,
    input  logic pop,
    output logic empty,
    output T     dout
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T               slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// File: sv/rplm_engine.sv
module rplm_engine #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [rplm_pkg::CFG_W-1:0]  table_entries,
    input  logic                        req_empty,
    output logic                        req_pop,
    input  rplm_pkg::req_t              req,
    input  logic                        rsp_full,
    output logic                        rsp_push,
    output rplm_pkg::rsp_t              rsp
);

    import rplm_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = (AW > 10) ? AW : 10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    state_t         state_reg, state_next;
    logic [31:0]    addr_reg, addr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  issue_reg, issue_next;
    logic           rd_vld_reg, rd_vld_next;
    logic [CW-1:0]  rd_idx_reg, rd_idx_next;
    logic           found_reg, found_next;
    logic [31:0]    best_mask_reg, best_mask_next;
    logic [31:0]    best_hop_reg, best_hop_next;
    logic [3:0]     best_port_reg, best_port_next;
    logic [9:0]     best_idx_reg, best_idx_next;

    entry_t         table_mem [TABLE_DEPTH];
    entry_t         rd_data_reg;
    logic           mem_we;
    logic [AW-1:0]  mem_wa;
    entry_t         mem_wd;
    logic [IW-1:0]  slot_ext;
    logic [31:0]    cfg_ext;
    logic           match, better;

    assign slot_ext = IW'(req.entry_index);
    assign cfg_ext  = 32'(table_entries);
    assign mem_wa   = slot_ext[AW-1:0];
    assign mem_wd   = '{prefix: req.entry_prefix, mask: req.entry_mask,
                        hop: req.entry_next_hop, port: req.entry_port};

    assign match  = ((rd_data_reg.prefix & rd_data_reg.mask)
                    == (addr_reg & rd_data_reg.mask));
    assign better = !found_reg || (rd_data_reg.mask > best_mask_reg);

    assign rsp.found         = found_reg;
    assign rsp.hop_address   = best_hop_reg;
    assign rsp.out_port      = best_port_reg;
    assign rsp.matched_index = best_idx_reg;

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = issue_reg;
        found_next     = found_reg;
        best_mask_next = best_mask_reg;
        best_hop_next  = best_hop_reg;
        best_port_next = best_port_reg;
        best_idx_next  = best_idx_reg;
        req_pop        = 1'b0;
        rsp_push       = 1'b0;
        mem_we         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!req_empty)
                begin
                    req_pop = 1'b1;
                    if (req.op == OP_WRITE)
                    begin
                        // Slots beyond the table are dropped.
                        mem_we = (32'(slot_ext) < 32'(TABLE_DEPTH));
                    end
                    else
                    begin
                        addr_next      = req.lookup_address;
                        count_next     = (cfg_ext > 32'(TABLE_DEPTH)) ?
                                         CW'(TABLE_DEPTH) : CW'(cfg_ext);
                        issue_next     = '0;
                        found_next     = 1'b0;
                        best_mask_next = '0;
                        best_hop_next  = '0;
                        best_port_next = '0;
                        best_idx_next  = '0;
                        state_next     = (cfg_ext == 32'd0) ? ST_RESULT : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue_reg < count_reg)
                begin
                    rd_vld_next = 1'b1;
                    issue_next  = issue_reg + 1'b1;
                end
                if (rd_vld_reg)
                begin
                    if (match && better)
                    begin
                        found_next     = 1'b1;
                        best_mask_next = rd_data_reg.mask;
                        best_hop_next  = rd_data_reg.hop;
                        best_port_next = rd_data_reg.port;
                        best_idx_next  = 10'(rd_idx_reg);
                    end
                    if (rd_idx_reg == count_reg - CW'(1))
                    begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_RESULT:
            begin
                if (!rsp_full)
                begin
                    rsp_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            addr_reg      <= '0;
            count_reg     <= '0;
            issue_reg     <= '0;
            rd_idx_reg    <= '0;
            best_mask_reg <= '0;
            best_hop_reg  <= '0;
            best_port_reg <= '0;
            best_idx_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_vld_reg    <= rd_vld_next;
            found_reg     <= found_next;
            addr_reg      <= addr_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            rd_idx_reg    <= rd_idx_next;
            best_mask_reg <= best_mask_next;
            best_hop_reg  <= best_hop_next;
            best_port_reg <= best_port_next;
            best_idx_reg  <= best_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= table_mem[issue_reg[AW-1:0]];
    end

endmodule

// File: sv/route_longest_prefix_lookup_top.sv
// IPv4 route table with longest-prefix lookup. A request either writes one
// route slot (prefix, mask, next hop, interface) or looks up an address;
// only lookups produce a result. A lookup compares the address against slots
// 0 up to table_entries-1 (capped at TABLE_DEPTH), picks the matching slot
// with the numerically largest mask, lowest slot on a tie, and reports its
// next hop, interface and slot number, or all zeros with found low. Requests
// enter a short queue, the search engine drains it, and results leave through
// a second queue, so a stall on either side is absorbed until a queue fills.
// A write request is stored in the route memory as it is popped. A lookup
// first starts the scan, then the route memory delivers one slot per cycle
// for the N slots in use, each read registered before it is compared, and
// then the result is handed off. With no slot in use the scan is skipped.
// The hand-off waits for as long as the result queue is full. Table
// contents are undefined after reset, so no clearing pass is run; every
// slot that a lookup scans must be written first. The user must write
// table_entries through cfg_we and cfg_data only while no request is in
// flight; the block itself does not enforce this.
module route_longest_prefix_lookup_top #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  rplm_pkg::req_t              req_data,
    output logic                        empty,
    input  logic                        pop,
    output rplm_pkg::rsp_t              rsp_data,
    input  logic                        cfg_we,
    input  logic [rplm_pkg::CFG_W-1:0]  cfg_data
);

    import rplm_pkg::*;

    // Number of slots in use; read by the engine when a lookup starts.
    logic [CFG_W-1:0] table_entries_reg;

    logic   req_empty, req_pop;
    req_t   req_head;
    logic   rsp_full, rsp_push;
    rsp_t   rsp_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_entries_reg <= '0;
        end
        else if (cfg_we)
        begin
            table_entries_reg <= cfg_data;
        end
    end

    // Front end: incoming requests wait here until the engine is free.
    rplm_queue #(
        .T     (req_t),
        .DEPTH (2)
    ) u_req_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .din   (req_data),
        .pop   (req_pop),
        .empty (req_empty),
        .dout  (req_head)
    );

    // Back end: decodes each request, updates the table or scans it.
    rplm_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .table_entries (table_entries_reg),
        .req_empty     (req_empty),
        .req_pop       (req_pop),
        .req           (req_head),
        .rsp_full      (rsp_full),
        .rsp_push      (rsp_push),
        .rsp           (rsp_new)
    );

    // Finished results wait here until the consumer pops them.
    rplm_queue #(
        .T     (rsp_t),
        .DEPTH (2)
    ) u_rsp_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rsp_push),
        .full  (rsp_full),
        .din   (rsp_new),
        .pop   (pop),
        .empty (empty),
        .dout  (rsp_data)
    );

endmodule
